/* rtl/bge_pkg.sv */
package bge_pkg;

    localparam int GLYPH_ROWS = 16;
    localparam int ROW_IDX_W  = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [1:0]  OP_WRITE_INDEX = 2'd0;
    localparam logic [1:0]  OP_WRITE_ROW   = 2'd1;
    localparam logic [1:0]  OP_RENDER      = 2'd2;

    localparam logic [7:0]  CFG_PIXEL_VALUE = 8'd0;
    localparam logic [7:0]  CFG_DOUBLE_SIZE = 8'd1;

    localparam logic [15:0] MISSING_ENTRY = 16'hFFFF;
    localparam logic [15:0] FALLBACK_CODE = 16'h2100;
    localparam logic [15:0] SHIFT_LIMIT   = 16'd256;

    localparam logic [7:0]  PIXEL_VALUE_RESET = 8'hFF;

    typedef enum logic [1:0] {
        CMD_INDEX,
        CMD_ROW,
        CMD_RENDER
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] code;
        logic [15:0] data;
        logic [15:0] glyph;
        logic [3:0]  row;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_FALLBACK,
        BK_ROW_READ,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       double_size;
    } cfg_t;

endpackage

/* rtl/bge_front.sv */
module bge_front #(
    parameter int GLYPH_COUNT = 8192
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [15:0]       char_code,
    input  logic [15:0]       index_value,
    input  logic [12:0]       glyph_number,
    input  logic [3:0]        glyph_row,
    input  logic [15:0]       row_bits,
    output logic              push_valid,
    input  logic              push_ready,
    output bge_pkg::cmd_t     push_cmd
);
    import bge_pkg::*;

    localparam logic [16:0] GLYPH_LIMIT = 17'(GLYPH_COUNT);

    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic front_valid_reg;
    logic front_valid_next;
    logic keep;
    logic load;

    always_comb
    begin
        keep           = 1'b0;
        cmd_next       = cmd_reg;
        cmd_next.code  = char_code;
        cmd_next.data  = index_value;
        cmd_next.glyph = {3'b000, glyph_number};
        cmd_next.row   = glyph_row;
        case (opcode)
            OP_WRITE_INDEX:
            begin
                keep          = 1'b1;
                cmd_next.kind = CMD_INDEX;
            end
            OP_WRITE_ROW:
            begin
                keep          = ({4'b0000, glyph_number} < GLYPH_LIMIT);
                cmd_next.kind = CMD_ROW;
                cmd_next.data = row_bits;
            end
            OP_RENDER:
            begin
                keep          = 1'b1;
                cmd_next.kind = CMD_RENDER;
                if (char_code < SHIFT_LIMIT)
                begin
                    cmd_next.code = {char_code[7:0], 8'h00};
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready         = !front_valid_reg || push_ready;
    assign load             = in_valid && in_ready && keep;
    assign front_valid_next = load || (front_valid_reg && !push_ready);
    assign push_valid       = front_valid_reg;
    assign push_cmd         = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* rtl/bge_queue.sv */
module bge_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  bge_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output bge_pkg::cmd_t pop_cmd
);
    import bge_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/bge_back.sv */
module bge_back #(
    parameter int GLYPH_COUNT = 8192
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bge_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  bge_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [4:0]    out_row,
    output logic [1:0]    chunk,
    output logic [63:0]   pixels,
    output logic          repeat_row,
    output logic          last
);
    import bge_pkg::*;

    localparam int GW          = $clog2(GLYPH_COUNT);
    localparam int SAW         = GW + ROW_IDX_W;
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam logic [16:0] GLYPH_LIMIT = 17'(GLYPH_COUNT);

    logic [15:0] index_table [65536];
    logic [15:0] row_store [STORE_DEPTH];

    bk_state_t   state_reg;
    bk_state_t   state_next;

    logic [15:0]          tbl_rd_reg;
    logic [15:0]          tbl_rd_addr;
    logic [15:0]          row_data_reg;
    logic [ROW_IDX_W-1:0] st_rd_row;
    logic [SAW-1:0]       st_rd_addr;
    logic [SAW-1:0]       st_wr_addr;
    logic                 st_rd_en;
    logic                 tbl_we;
    logic                 st_we;
    logic                 fire;

    logic [GW-1:0]        glyph_reg;
    logic [GW-1:0]        glyph_next;
    logic                 blank_reg;
    logic                 blank_next;
    logic [ROW_IDX_W-1:0] row_reg;
    logic [ROW_IDX_W-1:0] row_next;
    logic [1:0]           chunk_reg;
    logic [1:0]           chunk_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [4:0]           out_row_reg;
    logic [1:0]           chunk_out_reg;
    logic [63:0]          pixels_reg;
    logic                 repeat_reg;
    logic                 last_reg;

    logic                 usable;
    logic                 last_chunk;
    logic                 last_item;
    logic [63:0]          pix;

    assign usable     = (tbl_rd_reg != MISSING_ENTRY) && ({1'b0, tbl_rd_reg} < GLYPH_LIMIT);
    assign last_chunk = cfg.double_size ? (chunk_reg == 2'd3) : (chunk_reg == 2'd1);
    assign last_item  = last_chunk && (row_reg == ROW_IDX_W'(GLYPH_ROWS - 1));
    assign fire       = (state_reg == BK_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && (q_cmd.kind == CMD_RENDER))
                begin
                    state_next = BK_LOOKUP;
                end
            end
            BK_LOOKUP:
            begin
                state_next = usable ? BK_ROW_READ : BK_FALLBACK;
            end
            BK_FALLBACK:
            begin
                state_next = BK_ROW_READ;
            end
            BK_ROW_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (fire && last_item)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop       = 1'b0;
        tbl_we      = 1'b0;
        st_we       = 1'b0;
        st_rd_en    = 1'b0;
        st_rd_row   = row_reg;
        tbl_rd_addr = FALLBACK_CODE;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop       = q_valid;
                tbl_we      = q_valid && (q_cmd.kind == CMD_INDEX);
                st_we       = q_valid && (q_cmd.kind == CMD_ROW);
                tbl_rd_addr = q_cmd.code;
            end
            BK_ROW_READ:
            begin
                st_rd_en = 1'b1;
            end
            BK_EMIT:
            begin
                st_rd_en  = fire && last_chunk && !last_item;
                st_rd_row = row_reg + 1'b1;
            end
            default:
            begin
                st_rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        glyph_next = glyph_reg;
        blank_next = blank_reg;
        row_next   = row_reg;
        chunk_next = chunk_reg;
        case (state_reg)
            BK_IDLE:
            begin
                row_next   = '0;
                chunk_next = '0;
            end
            BK_LOOKUP:
            begin
                glyph_next = tbl_rd_reg[GW-1:0];
                blank_next = 1'b0;
            end
            BK_FALLBACK:
            begin
                glyph_next = usable ? tbl_rd_reg[GW-1:0] : '0;
                blank_next = !usable;
            end
            BK_EMIT:
            begin
                if (fire)
                begin
                    if (last_chunk)
                    begin
                        chunk_next = '0;
                        row_next   = row_reg + 1'b1;
                    end
                    else
                    begin
                        chunk_next = chunk_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                glyph_next = glyph_reg;
            end
        endcase
    end

    always_comb
    begin
        logic [3:0] src;
        pix = '0;
        for (int p = 0; p < 8; p++)
        begin
            src = cfg.double_size ? {chunk_reg, 2'(p >> 1)} : {chunk_reg[0], 3'(p)};
            if (row_data_reg[~src] && !blank_reg)
            begin
                pix[8*p +: 8] = cfg.pixel_value;
            end
        end
    end

    assign out_valid_next = fire || (out_valid_reg && !out_ready);
    assign st_rd_addr     = {glyph_reg, st_rd_row};
    assign st_wr_addr     = {q_cmd.glyph[GW-1:0], q_cmd.row};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        blank_reg <= blank_next;
        row_reg   <= row_next;
        chunk_reg <= chunk_next;
        if (fire)
        begin
            out_row_reg   <= cfg.double_size ? {row_reg, 1'b0} : {1'b0, row_reg};
            chunk_out_reg <= chunk_reg;
            pixels_reg    <= pix;
            repeat_reg    <= cfg.double_size;
            last_reg      <= last_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            index_table[q_cmd.code] <= q_cmd.data;
        end
        tbl_rd_reg <= index_table[tbl_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            row_store[st_wr_addr] <= q_cmd.data;
        end
        if (st_rd_en)
        begin
            row_data_reg <= row_store[st_rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign chunk      = chunk_out_reg;
    assign pixels     = pixels_reg;
    assign repeat_row = repeat_reg;
    assign last       = last_reg;

endmodule

/* rtl/bitmap_glyph_expander_core.sv */
// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------------------
// input     in_valid / in_ready   opcode, char_code, index_value, glyph_number,
//                                 glyph_row, row_bits
// config    cfg_valid / cfg_ready cfg_index, cfg_data
// output    out_valid / out_ready out_row, chunk, pixels, repeat_row, last
//
// A write item is applied in the idle state. A render passes the lookup, fallback (only when
// the fallback entry is consulted) and first row read states, then one output transfer per cycle
// when not stalled: 32 in single and 64 in double mode, paced by the single output register.
// Reset clears only control state; both memories are undefined until written.
// An output stall holds the back end while a four-entry queue lets the front keep taking items.
module bitmap_glyph_expander_core #(
    parameter int GLYPH_COUNT = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] char_code,
    input  logic [15:0] index_value,
    input  logic [12:0] glyph_number,
    input  logic [3:0]  glyph_row,
    input  logic [15:0] row_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  out_row,
    output logic [1:0]  chunk,
    output logic [63:0] pixels,
    output logic        repeat_row,
    output logic        last
);
    import bge_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PIXEL_VALUE:
                begin
                    cfg_next.pixel_value = cfg_data;
                end
                CFG_DOUBLE_SIZE:
                begin
                    cfg_next.double_size = cfg_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_value <= PIXEL_VALUE_RESET;
            cfg_reg.double_size <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bge_front #(
        .GLYPH_COUNT(GLYPH_COUNT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .char_code(char_code),
        .index_value(index_value),
        .glyph_number(glyph_number),
        .glyph_row(glyph_row),
        .row_bits(row_bits),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd(push_cmd)
    );

    bge_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd(push_cmd),
        .pop_valid(q_valid),
        .pop(q_pop),
        .pop_cmd(q_cmd)
    );

    bge_back #(
        .GLYPH_COUNT(GLYPH_COUNT)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .q_valid(q_valid),
        .q_cmd(q_cmd),
        .q_pop(q_pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_row(out_row),
        .chunk(chunk),
        .pixels(pixels),
        .repeat_row(repeat_row),
        .last(last)
    );

endmodule

/* rtl/bge_checker.sv */
module bge_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  out_row,
    input logic [1:0]  chunk,
    input logic [63:0] pixels,
    input logic        repeat_row,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before its transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixels) && $stable(out_row) && $stable(chunk))
        else $error("output payload changed while stalled");

    a_mode_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (repeat_row ? (out_row[0] == 1'b0) : (chunk[1] == 1'b0 && out_row[4] == 1'b0)))
        else $error("row or chunk outside the range of the current mode");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (repeat_row ? (chunk == 2'd3 && out_row == 5'd30)
                                          : (chunk == 2'd1 && out_row == 5'd15)))
        else $error("end of render marked away from the final chunk");

endmodule

bind bitmap_glyph_expander_core bge_checker u_bge_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_row(out_row),
    .chunk(chunk),
    .pixels(pixels),
    .repeat_row(repeat_row),
    .last(last)
);

/* verif/tb_bitmap_glyph_expander_core.sv */
module tb_bitmap_glyph_expander_core;

    timeunit 1ns;
    timeprecision 1ps;

    import bge_pkg::*;

    localparam int GLYPH_COUNT = 8192;
    localparam int PHASE_ITEMS = 64;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  opcode;
        logic [15:0] char_code;
        logic [15:0] index_value;
        logic [12:0] glyph_number;
        logic [3:0]  glyph_row;
        logic [15:0] row_bits;
    } glyph_cmd_t;

    typedef struct packed {
        logic [4:0]  out_row;
        logic [1:0]  chunk;
        logic [63:0] pixels;
        logic        repeat_row;
        logic        last;
    } pixel_chunk_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [15:0] char_code = '0;
    logic [15:0] index_value = '0;
    logic [12:0] glyph_number = '0;
    logic [3:0]  glyph_row = '0;
    logic [15:0] row_bits = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  out_row;
    logic [1:0]  chunk;
    logic [63:0] pixels;
    logic        repeat_row;
    logic        last;

    glyph_cmd_t   cmd_backlog[$];
    pixel_chunk_t chunks_due[$];

    // Contents as the block will hold them once every accepted command has been applied.
    logic [15:0] code_map[int];
    logic [15:0] row_bitmap[int];
    cfg_t        live_cfg = '{pixel_value: PIXEL_VALUE_RESET, double_size: 1'b0};

    // Contents as they will be once every queued command has been applied.
    logic [15:0] planned_map[int];
    logic [15:0] planned_rows[int];
    int          planned_codes[$];
    int          ready_glyphs[$];

    int sent = 0;
    int planned = 0;
    int taken = 0;
    int renders = 0;
    int chunks_checked = 0;
    int fails = 0;
    int settings = 1;
    bit calm = 1'b0;

    int tx_gap = 0;
    int rx_gap = 0;
    bit tx_jitter = 1'b1;
    bit rx_jitter = 1'b1;

    bitmap_glyph_expander_core #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .char_code    (char_code),
        .index_value  (index_value),
        .glyph_number (glyph_number),
        .glyph_row    (glyph_row),
        .row_bits     (row_bits),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_row      (out_row),
        .chunk        (chunk),
        .pixels       (pixels),
        .repeat_row   (repeat_row),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit usable_glyph(input logic [15:0] g);
        return g != MISSING_ENTRY && g < GLYPH_COUNT;
    endfunction

    function automatic logic [15:0] lookup_key(input logic [15:0] code);
        return (code < SHIFT_LIMIT) ? {code[7:0], 8'h00} : code;
    endfunction

    task automatic expand_glyph(input logic [15:0] code);
        logic [15:0]  g;
        logic [15:0]  bits;
        bit           blank;
        int           chunks_per_row;
        int           bits_per_chunk;
        int           total;
        int           src;
        int           n;
        pixel_chunk_t res;
        g = code_map[int'(lookup_key(code))];
        blank = 1'b0;
        if (!usable_glyph(g))
        begin
            g = code_map[int'(FALLBACK_CODE)];
            blank = !usable_glyph(g);
        end
        chunks_per_row = live_cfg.double_size ? 4 : 2;
        bits_per_chunk = live_cfg.double_size ? 4 : 8;
        total = chunks_per_row * GLYPH_ROWS;
        n = 0;
        for (int row = 0; row < GLYPH_ROWS; row++)
        begin
            bits = blank ? 16'h0000 : row_bitmap[int'(g) * GLYPH_ROWS + row];
            for (int c = 0; c < chunks_per_row; c++)
            begin
                res.pixels = '0;
                for (int p = 0; p < 8; p++)
                begin
                    src = c * bits_per_chunk + (live_cfg.double_size ? p / 2 : p);
                    if (bits[15 - src])
                        res.pixels[8 * p +: 8] = live_cfg.pixel_value;
                end
                res.out_row = 5'(live_cfg.double_size ? row * 2 : row);
                res.chunk = 2'(c);
                res.repeat_row = live_cfg.double_size;
                res.last = (n + 1 == total);
                chunks_due.push_back(res);
                n++;
            end
        end
    endtask

    task automatic absorb_command();
        case (opcode)
            OP_WRITE_INDEX: code_map[int'(char_code)] = index_value;
            OP_WRITE_ROW:
                if (glyph_number < GLYPH_COUNT)
                    row_bitmap[int'(glyph_number) * GLYPH_ROWS + int'(glyph_row)] = row_bits;
            OP_RENDER:
            begin
                expand_glyph(char_code);
                renders++;
            end
            default: ;
        endcase
        taken++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        glyph_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_command();
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && tx_jitter && $urandom_range(0, 7) == 0)
                begin
                    tx_gap <= $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    nxt = cmd_backlog.pop_front();
                    opcode <= nxt.opcode;
                    char_code <= nxt.char_code;
                    index_value <= nxt.index_value;
                    glyph_number <= nxt.glyph_number;
                    glyph_row <= nxt.glyph_row;
                    row_bits <= nxt.row_bits;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            if ($urandom_range(0, 199) == 0)
                tx_jitter <= !tx_jitter;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_chunk_t want;
        pixel_chunk_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{out_row, chunk, pixels, repeat_row, last};
                if (chunks_due.size() == 0)
                begin
                    $display("%0t: expected nothing, got row %0d chunk %0d pixels %h repeat %0b last %0b",
                             $time, got.out_row, got.chunk, got.pixels, got.repeat_row, got.last);
                    fails++;
                end
                else
                begin
                    want = chunks_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected row %0d chunk %0d pixels %h repeat %0b last %0b",
                                 $time, want.out_row, want.chunk, want.pixels, want.repeat_row,
                                 want.last);
                        $display("%0t: actual   row %0d chunk %0d pixels %h repeat %0b last %0b",
                                 $time, got.out_row, got.chunk, got.pixels, got.repeat_row,
                                 got.last);
                        fails++;
                    end
                    chunks_checked++;
                end
            end
            if (rx_gap != 0)
            begin
                rx_gap <= rx_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && rx_jitter && $urandom_range(0, 9) == 0)
            begin
                rx_gap <= $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                rx_jitter <= !rx_jitter;
        end
    end

    task automatic queue_cmd(input logic [1:0] op, input logic [15:0] code,
                             input logic [15:0] value, input logic [12:0] g,
                             input logic [3:0] r, input logic [15:0] bits);
        glyph_cmd_t cmd;
        cmd = '{op, code, value, g, r, bits};
        cmd_backlog.push_back(cmd);
        sent++;
        if (op != OP_UNUSED)
            planned++;
    endtask

    task automatic push_index(input logic [15:0] code, input logic [15:0] value);
        planned_map[int'(code)] = value;
        planned_codes.push_back(int'(code));
        queue_cmd(OP_WRITE_INDEX, code, value, 13'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic push_row(input logic [12:0] g, input logic [3:0] r, input logic [15:0] bits);
        bit was_full;
        was_full = planned_rows.exists(int'(g)) && planned_rows[int'(g)] == 16'hFFFF;
        if (!planned_rows.exists(int'(g)))
            planned_rows[int'(g)] = 16'h0000;
        planned_rows[int'(g)] = planned_rows[int'(g)] | (16'h0001 << r);
        if (!was_full && planned_rows[int'(g)] == 16'hFFFF)
            ready_glyphs.push_back(int'(g));
        queue_cmd(OP_WRITE_ROW, 16'($urandom), 16'($urandom), g, r, bits);
    endtask

    task automatic push_render(input logic [15:0] code);
        queue_cmd(OP_RENDER, code, 16'($urandom), 13'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic push_noise();
        queue_cmd(OP_UNUSED, 16'($urandom), 16'($urandom), 13'($urandom), 4'($urandom),
                  16'($urandom));
    endtask

    // A render is legal only if every table entry and glyph row it reads has been written.
    function automatic bit can_render(input logic [15:0] code);
        logic [15:0] g;
        int key;
        key = int'(lookup_key(code));
        if (!planned_map.exists(key))
            return 1'b0;
        g = planned_map[key];
        if (!usable_glyph(g))
        begin
            if (!planned_map.exists(int'(FALLBACK_CODE)))
                return 1'b0;
            g = planned_map[int'(FALLBACK_CODE)];
            if (!usable_glyph(g))
                return 1'b1;
        end
        return planned_rows.exists(int'(g)) && planned_rows[int'(g)] == 16'hFFFF;
    endfunction

    task automatic build_glyph();
        int          rows_left[$];
        int          g;
        int          k;
        int          pick;
        logic [15:0] bits;
        pick = $urandom_range(0, 3);
        g = (pick == 0) ? 0 : (pick == 1) ? GLYPH_COUNT - 1 : $urandom_range(0, GLYPH_COUNT - 1);
        for (k = 0; k < GLYPH_ROWS; k++)
            rows_left.push_back(k);
        while (rows_left.size() != 0)
        begin
            k = $urandom_range(0, rows_left.size() - 1);
            pick = $urandom_range(0, 9);
            bits = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom);
            push_row(13'(g), 4'(rows_left[k]), bits);
            rows_left.delete(k);
        end
    endtask

    task automatic random_index_write();
        logic [15:0] code;
        logic [15:0] value;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            code = FALLBACK_CODE;
        else if (pick < 45)
            code = {8'($urandom), 8'h00};
        else
            code = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 65 && ready_glyphs.size() != 0)
            value = 16'(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]);
        else if (pick < 80)
            value = MISSING_ENTRY;
        else if (pick < 90)
            value = 16'($urandom_range(GLYPH_COUNT, 16'hFFFE));
        else
            value = 16'($urandom);
        push_index(code, value);
    endtask

    task automatic random_step();
        int          sel;
        int          k;
        bit          done;
        logic [15:0] code;
        sel = $urandom_range(0, 99);
        done = 1'b0;
        if (ready_glyphs.size() == 0 || sel < 8)
            build_glyph();
        else if (sel < 28)
            random_index_write();
        else if (sel < 40)
            push_row(13'(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]),
                     4'($urandom), 16'($urandom));
        else if (sel < 44)
            push_noise();
        else
        begin
            for (k = 0; k < 8 && !done && planned_codes.size() != 0; k++)
            begin
                code = 16'(planned_codes[$urandom_range(0, planned_codes.size() - 1)]);
                if (code[7:0] == 8'h00 && $urandom_range(0, 1) == 1)
                    code = code >> 8;
                if (can_render(code))
                begin
                    push_render(code);
                    done = 1'b1;
                end
            end
            if (!done)
                random_index_write();
        end
    endtask

    task automatic drain();
        while (taken != sent || chunks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PIXEL_VALUE)
            live_cfg.pixel_value = val;
        else if (idx == CFG_DOUBLE_SIZE)
            live_cfg.double_size = val[0];
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] pv;
        logic       dbl;
        int         target;
        bit         paused;
        paused = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            case (r)
                0: push_row(13'(GLYPH_COUNT - 1), 4'(r), 16'hFFFF);
                1: push_row(13'(GLYPH_COUNT - 1), 4'(r), 16'h0000);
                2: push_row(13'(GLYPH_COUNT - 1), 4'(r), 16'h8000);
                3: push_row(13'(GLYPH_COUNT - 1), 4'(r), 16'h0001);
                4: push_row(13'(GLYPH_COUNT - 1), 4'(r), 16'hAAAA);
                5: push_row(13'(GLYPH_COUNT - 1), 4'(r), 16'h5555);
                default: push_row(13'(GLYPH_COUNT - 1), 4'(r), 16'($urandom));
            endcase
        end
        push_index(16'h4100, 16'(GLYPH_COUNT - 1));
        push_index(FALLBACK_CODE, 16'(GLYPH_COUNT - 1));
        push_index(16'h1234, MISSING_ENTRY);
        push_index(16'hFFFF, 16'(GLYPH_COUNT));
        push_render(16'h0041);
        push_render(16'hFFFF);
        push_render(16'h1234);
        push_noise();
        // With the fallback entry marked missing as well, the glyph comes out blank.
        push_index(FALLBACK_CODE, MISSING_ENTRY);
        push_render(16'h1234);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin pv = 8'h00; dbl = 1'b1; end
                1: begin pv = 8'h80; dbl = 1'b0; end
                2: begin pv = 8'($urandom); dbl = 1'b1; end
                3: begin pv = 8'hFF; dbl = 1'b1; end
                4: begin pv = 8'h01; dbl = 1'b0; end
                default:
                begin
                    pv = 8'($urandom);
                    dbl = 1'($urandom);
                    calm = 1'b1;
                end
            endcase
            write_reg(CFG_PIXEL_VALUE, pv);
            write_reg(CFG_DOUBLE_SIZE, {7'd0, dbl});
            settings++;
            target = planned + PHASE_ITEMS;
            while (planned < target)
            begin
                // Hold the sender back once until the output side has caught up completely.
                if (ph == 1 && !paused && planned >= target - PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                random_step();
            end
            drain();
        end

        $display("summary: %0d commands transferred, %0d renders, %0d pixel chunks checked",
                 taken, renders, chunks_checked);
        $display("summary: %0d register settings across single and double size", settings);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("tb: failure");
        $finish;
    end

endmodule

/* bitmap_glyph_expander_core.f */
rtl/bge_pkg.sv
rtl/bge_front.sv
rtl/bge_queue.sv
rtl/bge_back.sv
rtl/bitmap_glyph_expander_core.sv
rtl/bge_checker.sv
verif/tb_bitmap_glyph_expander_core.sv
